@@ hdl/wav_stream_parser_top_assert.svh @@
// assertion macros for the wav stream parser
`ifndef WAV_STREAM_PARSER_TOP_ASSERT_SVH
`define WAV_STREAM_PARSER_TOP_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define WSP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wav stream parser check failed");

// consequent holds in the cycle after the antecedent
`define WSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wav stream parser check failed");

`endif

@@ hdl/wsp_pkg.sv @@
`default_nettype none

package wsp_pkg;

    // header tags, first byte in the top bits
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // byte positions inside the fixed header
    localparam logic [5:0] HP_RIFF_END = 6'd3;
    localparam logic [5:0] HP_WAVE_END = 6'd11;
    localparam logic [5:0] HP_FMT_END  = 6'd15;
    localparam logic [5:0] HP_FMT_LO   = 6'd20;
    localparam logic [5:0] HP_FMT_HI   = 6'd21;
    localparam logic [5:0] HP_CH_LO    = 6'd22;
    localparam logic [5:0] HP_CH_HI    = 6'd23;
    localparam logic [5:0] HP_RATE_0   = 6'd24;
    localparam logic [5:0] HP_RATE_1   = 6'd25;
    localparam logic [5:0] HP_RATE_2   = 6'd26;
    localparam logic [5:0] HP_RATE_3   = 6'd27;
    localparam logic [5:0] HP_ALIGN_LO = 6'd32;
    localparam logic [5:0] HP_ALIGN_HI = 6'd33;
    localparam logic [5:0] HP_WIDTH_LO = 6'd34;
    localparam logic [5:0] HP_WIDTH_HI = 6'd35;
    localparam logic [5:0] HP_LEN_END  = 6'd3;

    localparam logic [15:0] FMT_PCM  = 16'd1;
    localparam logic [15:0] WIDTH_8  = 16'd8;
    localparam logic [15:0] WIDTH_16 = 16'd16;
    localparam logic [15:0] WIDTH_32 = 16'd32;

    // divider: one quotient bit per cycle
    localparam int unsigned    DIV_STEPS = 32;
    localparam int unsigned    DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam int unsigned OUT_TDATA_W = 152;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NOT_RIFF  = 3'd1,
        ERR_NOT_WAVE  = 3'd2,
        ERR_NOT_PCM   = 3'd3,
        ERR_TRUNCATED = 3'd4,
        ERR_ZERO_ALGN = 3'd5,
        ERR_BAD_WIDTH = 3'd6
    } t_err;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_HEAD = 3'd1,
        OP_SCAN = 3'd2,
        OP_LEN  = 3'd3,
        OP_DATA = 3'd4,
        OP_LOAD = 3'd5
    } t_op;

    // controller to datapath
    typedef struct packed {
        t_op   op;
        logic  div_start;
        logic  out_load;
        t_kind kind;
        t_err  err;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic riff_bad;
        logic wave_bad;
        logic pcm_bad;
        logic head_done;
        logic data_hit;
        logic len_done;
        logic align_zero;
        logic width_bad;
        logic sample_done;
        logic last_next;
        logic samples_zero;
        logic div_done;
        logic fc_zero;
    } t_stat;

    // one result item
    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] sample;
        logic               last_sample;
        logic [15:0]        channels;
        logic [31:0]        sample_rate;
        logic [15:0]        block_align;
        logic [15:0]        bits_per_sample;
        logic [31:0]        frame_count;
        t_err               error_code;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/wsp_div.sv @@
`default_nettype none

module wsp_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [15:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quotient
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [wsp_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]                   r_q, n_q;
    logic [15:0]                   r_rem, n_rem;
    logic [15:0]                   r_dvs, n_dvs;

    logic [16:0] rem_sh;
    logic [16:0] diff;
    logic        ge;

    // restoring step: shift in next dividend bit, subtract if it fits
    assign rem_sh = {r_rem, r_q[31]};
    assign diff   = rem_sh - {1'b0, r_dvs};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = wsp_pkg::DIV_CNT_W'(wsp_pkg::DIV_STEPS);
            n_q    = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[15:0] : rem_sh[15:0];
            n_q   = {r_q[30:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == wsp_pkg::DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // operands
    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

@@ hdl/wsp_dp.sv @@
`default_nettype none

module wsp_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_start,
    input  wire wsp_pkg::t_cmd    i_cmd,
    output wsp_pkg::t_stat        o_stat,
    output wsp_pkg::t_result      o_res
);

    logic [5:0]  r_hp, n_hp;
    logic [31:0] r_win, n_win;
    logic [31:0] r_fa, n_fa;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_align, n_align;
    logic [15:0] r_width, n_width;
    logic [31:0] r_left, n_left;
    logic [1:0]  r_idx, n_idx;
    wsp_pkg::t_result r_res, n_res;

    logic [5:0]  eff_hp;
    logic [31:0] eff_win;
    logic [31:0] eff_fa;
    logic [31:0] win_next;
    logic [31:0] len_fa;
    logic [31:0] data_fa;
    logic [1:0]  last_idx;
    logic signed [31:0] sample_val;
    logic        div_done;
    logic [31:0] quot;

    // a start byte is position zero of a fresh parse
    assign eff_hp   = i_start ? '0 : r_hp;
    assign eff_win  = i_start ? '0 : r_win;
    assign eff_fa   = i_start ? '0 : r_fa;
    assign win_next = {eff_win[23:0], i_byte};

    // length field assembly, little endian
    always_comb begin
        len_fa = r_fa;
        unique case (r_hp[1:0])
            2'd0:    len_fa[7:0]   = i_byte;
            2'd1:    len_fa[15:8]  = i_byte;
            2'd2:    len_fa[23:16] = i_byte;
            default: len_fa[31:24] = i_byte;
        endcase
    end

    // sample assembly, little endian
    always_comb begin
        data_fa = r_fa;
        unique case (r_idx)
            2'd0:    data_fa[7:0]   = i_byte;
            2'd1:    data_fa[15:8]  = i_byte;
            2'd2:    data_fa[23:16] = i_byte;
            default: data_fa[31:24] = i_byte;
        endcase
    end

    // final byte index and sample decode by word length
    always_comb begin
        if (r_width == wsp_pkg::WIDTH_8) begin
            last_idx   = 2'd0;
            sample_val = {{24{~data_fa[7]}}, ~data_fa[7], data_fa[6:0]};
        end else if (r_width == wsp_pkg::WIDTH_16) begin
            last_idx   = 2'd1;
            sample_val = {{16{data_fa[15]}}, data_fa[15:0]};
        end else begin
            last_idx   = 2'd3;
            sample_val = data_fa;
        end
    end

    // status for the controller
    always_comb begin
        o_stat.riff_bad  = (eff_hp == wsp_pkg::HP_RIFF_END) && (win_next != wsp_pkg::TAG_RIFF);
        o_stat.wave_bad  = (eff_hp == wsp_pkg::HP_FMT_END)
                           && ((eff_fa != '0) || (win_next != wsp_pkg::TAG_FMT));
        o_stat.pcm_bad   = (eff_hp == wsp_pkg::HP_FMT_HI)
                           && ({i_byte, eff_fa[7:0]} != wsp_pkg::FMT_PCM);
        o_stat.head_done = (eff_hp >= wsp_pkg::HP_WIDTH_HI);
        o_stat.data_hit  = (win_next == wsp_pkg::TAG_DATA);
        o_stat.len_done  = (r_hp >= wsp_pkg::HP_LEN_END);
        o_stat.align_zero   = (r_align == '0);
        o_stat.width_bad    = !((r_width == wsp_pkg::WIDTH_8) || (r_width == wsp_pkg::WIDTH_16)
                                || (r_width == wsp_pkg::WIDTH_32));
        o_stat.sample_done  = (r_idx == last_idx);
        o_stat.last_next    = (r_left == 32'd1);
        o_stat.samples_zero = (r_left == '0);
        o_stat.div_done     = div_done;
        o_stat.fc_zero      = (quot == '0);
    end

    // frame count divider
    wsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (len_fa),
        .i_divisor  (r_align),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    // parse registers
    always_comb begin
        n_hp    = r_hp;
        n_win   = r_win;
        n_fa    = r_fa;
        n_chan  = r_chan;
        n_rate  = r_rate;
        n_align = r_align;
        n_width = r_width;
        n_left  = r_left;
        n_idx   = r_idx;
        unique case (i_cmd.op)
            wsp_pkg::OP_HEAD: begin
                n_win = win_next;
                n_fa  = eff_fa;
                if (eff_hp == wsp_pkg::HP_WAVE_END) begin
                    n_fa = {31'd0, win_next != wsp_pkg::TAG_WAVE};
                end
                if (eff_hp == wsp_pkg::HP_FMT_LO) begin
                    n_fa = {24'd0, i_byte};
                end
                if (eff_hp == wsp_pkg::HP_CH_LO)    n_chan[7:0]    = i_byte;
                if (eff_hp == wsp_pkg::HP_CH_HI)    n_chan[15:8]   = i_byte;
                if (eff_hp == wsp_pkg::HP_RATE_0)   n_rate[7:0]    = i_byte;
                if (eff_hp == wsp_pkg::HP_RATE_1)   n_rate[15:8]   = i_byte;
                if (eff_hp == wsp_pkg::HP_RATE_2)   n_rate[23:16]  = i_byte;
                if (eff_hp == wsp_pkg::HP_RATE_3)   n_rate[31:24]  = i_byte;
                if (eff_hp == wsp_pkg::HP_ALIGN_LO) n_align[7:0]   = i_byte;
                if (eff_hp == wsp_pkg::HP_ALIGN_HI) n_align[15:8]  = i_byte;
                if (eff_hp == wsp_pkg::HP_WIDTH_LO) n_width[7:0]   = i_byte;
                if (eff_hp == wsp_pkg::HP_WIDTH_HI) n_width[15:8]  = i_byte;
                if (o_stat.head_done) begin
                    n_hp  = '0;
                    n_win = '0;
                end else begin
                    n_hp = eff_hp + 6'd1;
                end
            end
            wsp_pkg::OP_SCAN: begin
                n_win = win_next;
                if (o_stat.data_hit) begin
                    n_hp = '0;
                    n_fa = '0;
                end
            end
            wsp_pkg::OP_LEN: begin
                n_fa = len_fa;
                if (!o_stat.len_done) begin
                    n_hp = r_hp + 6'd1;
                end
            end
            wsp_pkg::OP_DATA: begin
                if (o_stat.sample_done) begin
                    n_fa   = '0;
                    n_idx  = '0;
                    n_left = r_left - 32'd1;
                end else begin
                    n_fa  = data_fa;
                    n_idx = r_idx + 2'd1;
                end
            end
            wsp_pkg::OP_LOAD: begin
                n_left = quot;
                n_fa   = '0;
                n_idx  = '0;
                n_hp   = '0;
            end
            default: begin
            end
        endcase
    end

    // result item, unused fields zero
    always_comb begin
        n_res = r_res;
        if (i_cmd.out_load) begin
            n_res            = '0;
            n_res.kind       = i_cmd.kind;
            n_res.error_code = wsp_pkg::ERR_NONE;
            unique case (i_cmd.kind)
                wsp_pkg::KIND_HEADER: begin
                    n_res.channels        = r_chan;
                    n_res.sample_rate     = r_rate;
                    n_res.block_align     = r_align;
                    n_res.bits_per_sample = r_width;
                    n_res.frame_count     = quot;
                end
                wsp_pkg::KIND_SAMPLE: begin
                    n_res.sample      = sample_val;
                    n_res.last_sample = o_stat.last_next;
                end
                default: begin
                    n_res.error_code = i_cmd.err;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp    <= '0;
            r_win   <= '0;
            r_fa    <= '0;
            r_chan  <= '0;
            r_rate  <= '0;
            r_align <= '0;
            r_width <= '0;
            r_left  <= '0;
            r_idx   <= '0;
        end else begin
            r_hp    <= n_hp;
            r_win   <= n_win;
            r_fa    <= n_fa;
            r_chan  <= n_chan;
            r_rate  <= n_rate;
            r_align <= n_align;
            r_width <= n_width;
            r_left  <= n_left;
            r_idx   <= n_idx;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

@@ hdl/wsp_ctrl.sv @@
`default_nettype none

module wsp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_valid,
    input  wire logic          i_start,
    input  wire logic          i_end,
    input  wire logic          i_m_ready,
    input  wire wsp_pkg::t_stat i_stat,
    output logic               o_s_ready,
    output logic               o_m_valid,
    output wsp_pkg::t_cmd      o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_HEAD = 6'b000010,
        S_SCAN = 6'b000100,
        S_LEN  = 6'b001000,
        S_DIV  = 6'b010000,
        S_DATA = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_state eff_state;
    logic   r_end_hold, n_end_hold;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   in_fire;

    assign out_free  = !r_out_valid || i_m_ready;
    assign o_s_ready = (r_state != S_DIV) && out_free;
    assign in_fire   = i_s_valid && o_s_ready;
    assign eff_state = i_start ? S_HEAD : r_state;

    // next state and datapath commands
    always_comb begin
        n_state       = r_state;
        n_end_hold    = r_end_hold;
        o_cmd         = '0;
        o_cmd.op      = wsp_pkg::OP_NONE;
        o_cmd.kind    = wsp_pkg::KIND_HEADER;
        o_cmd.err     = wsp_pkg::ERR_NONE;
        if (in_fire) begin
            unique case (eff_state)
                S_HEAD: begin
                    o_cmd.op   = wsp_pkg::OP_HEAD;
                    o_cmd.kind = wsp_pkg::KIND_ERROR;
                    priority if (i_stat.riff_bad) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.err      = wsp_pkg::ERR_NOT_RIFF;
                        n_state        = S_IDLE;
                    end else if (i_stat.wave_bad) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.err      = wsp_pkg::ERR_NOT_WAVE;
                        n_state        = S_IDLE;
                    end else if (i_stat.pcm_bad) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.err      = wsp_pkg::ERR_NOT_PCM;
                        n_state        = S_IDLE;
                    end else if (i_end) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.err      = wsp_pkg::ERR_TRUNCATED;
                        n_state        = S_IDLE;
                    end else begin
                        n_state = i_stat.head_done ? S_SCAN : S_HEAD;
                    end
                end
                S_SCAN: begin
                    o_cmd.op   = wsp_pkg::OP_SCAN;
                    o_cmd.kind = wsp_pkg::KIND_ERROR;
                    if (i_end) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.err      = wsp_pkg::ERR_TRUNCATED;
                        n_state        = S_IDLE;
                    end else if (i_stat.data_hit) begin
                        n_state = S_LEN;
                    end
                end
                S_LEN: begin
                    o_cmd.op   = wsp_pkg::OP_LEN;
                    o_cmd.kind = wsp_pkg::KIND_ERROR;
                    priority if (i_stat.len_done && i_stat.align_zero) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.err      = wsp_pkg::ERR_ZERO_ALGN;
                        n_state        = S_IDLE;
                    end else if (i_stat.len_done) begin
                        o_cmd.div_start = 1'b1;
                        n_end_hold      = i_end;
                        n_state         = S_DIV;
                    end else if (i_end) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.err      = wsp_pkg::ERR_TRUNCATED;
                        n_state        = S_IDLE;
                    end else begin
                        n_state = S_LEN;
                    end
                end
                S_DATA: begin
                    priority if (i_stat.samples_zero) begin
                        n_state = S_IDLE;
                    end else if (i_stat.width_bad) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.kind     = wsp_pkg::KIND_ERROR;
                        o_cmd.err      = wsp_pkg::ERR_BAD_WIDTH;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.op = wsp_pkg::OP_DATA;
                        if (i_stat.sample_done) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.kind     = wsp_pkg::KIND_SAMPLE;
                            if (i_stat.last_next || i_end) begin
                                n_state = S_IDLE;
                            end
                        end else if (i_end) begin
                            n_state = S_IDLE;
                        end
                    end
                end
                S_IDLE, S_DIV: begin
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end else if ((r_state == S_DIV) && i_stat.div_done && out_free) begin
            // quotient ready: header item and sample count
            o_cmd.op       = wsp_pkg::OP_LOAD;
            o_cmd.out_load = 1'b1;
            o_cmd.kind     = wsp_pkg::KIND_HEADER;
            n_state        = (r_end_hold || i_stat.fc_zero) ? S_IDLE : S_DATA;
        end
    end

    // output item valid
    assign n_out_valid = (r_out_valid && !i_m_ready) || o_cmd.out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_end_hold  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_end_hold  <= n_end_hold;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_valid = r_out_valid;

endmodule

`default_nettype wire

@@ hdl/wav_stream_parser_top.sv @@
// a sample or error item appears in the cycle after the byte that completes it
// header item: follows the last data-length byte once the 32-step serial divider is done
// throughput: one byte per cycle while the output is free, input held off once per file while dividing
// an output item that is waiting and not taken holds off the input
// reset: synchronous active-low, parse goes idle and the output register empties
`default_nettype none

module wav_stream_parser_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,  // byte_value
    input  wire logic                              s_axis_tuser,  // file_start
    input  wire logic                              s_axis_tlast,  // file_end
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // sample, channels, sample_rate, block_align, bits_per_sample,
    // frame_count, error_code, zero fill
    output logic [wsp_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic [1:0]                             m_axis_tuser,  // kind
    output logic                                   m_axis_tlast   // last_sample
);

    `include "wav_stream_parser_top_assert.svh"

    wsp_pkg::t_cmd    cmd;
    wsp_pkg::t_stat   stat;
    wsp_pkg::t_result res;

    // header and sample datapath
    wsp_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (s_axis_tdata),
        .i_start (s_axis_tuser),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (res)
    );

    // parse sequencer
    wsp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_start   (s_axis_tuser),
        .i_end     (s_axis_tlast),
        .i_m_ready (m_axis_tready),
        .i_stat    (stat),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (cmd)
    );

    // output packing
    assign m_axis_tdata = {5'd0, res.error_code, res.frame_count, res.bits_per_sample,
                           res.block_align, res.sample_rate, res.channels, res.sample};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last_sample;

    // divider start holds off input
    `WSP_ASSERT_NEXT(a_div_stalls_input, cmd.div_start, !s_axis_tready)
    // a waiting item is never overwritten
    `WSP_ASSERT_SAME(a_no_overwrite, cmd.out_load, !m_axis_tvalid || m_axis_tready)
    // last marker only on samples
    `WSP_ASSERT_SAME(a_last_on_sample, m_axis_tvalid && m_axis_tlast,
                     m_axis_tuser == wsp_pkg::KIND_SAMPLE)
    // error items carry a code
    `WSP_ASSERT_SAME(a_err_has_code, cmd.out_load && (cmd.kind == wsp_pkg::KIND_ERROR),
                     cmd.err != wsp_pkg::ERR_NONE)

endmodule

`default_nettype wire

@@ sim/wav_stream_parser_checker.sv @@
`default_nettype none

module wav_stream_parser_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_tvalid,
    input  wire logic                          i_in_tready,
    input  wire logic [7:0]                    i_in_tdata,   // byte_value
    input  wire logic                          i_in_tuser,   // file_start
    input  wire logic                          i_in_tlast,   // file_end
    input  wire logic                          i_out_tvalid,
    input  wire logic                          i_out_tready,
    // sample, channels, sample_rate, block_align, bits_per_sample,
    // frame_count, error_code, zero fill
    input  wire logic [wsp_pkg::OUT_TDATA_W-1:0] i_out_tdata,
    input  wire logic [1:0]                    i_out_tuser,  // kind
    input  wire logic                          i_out_tlast,  // last_sample
    input  wire logic                          i_drain_done,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        PP_IDLE = 3'd0,
        PP_HEAD = 3'd1,
        PP_SCAN = 3'd2,
        PP_LEN  = 3'd3,
        PP_DATA = 3'd4
    } t_parse_phase;

    // parser state mirrored from the byte stream
    t_parse_phase phase_q     = PP_IDLE;
    logic [5:0]   hdr_pos     = '0;
    logic [31:0]  tag_win     = '0;
    logic [31:0]  field_acc   = '0;
    logic [15:0]  chan_reg    = '0;
    logic [31:0]  rate_reg    = '0;
    logic [15:0]  align_reg   = '0;
    logic [15:0]  width_reg   = '0;
    logic [31:0]  frames_left = '0;
    logic [1:0]   byte_idx    = '0;

    wsp_pkg::t_result decoded_due[$];
    int      fail_count    = 0;
    int      results_seen  = 0;
    logic    drain_checked = 1'b0;

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_results_seen = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("checker: result item %0d: %s", results_seen, msg);
        fail_count++;
    endtask

    task automatic clear_parse();
        hdr_pos     = '0;
        tag_win     = '0;
        field_acc   = '0;
        chan_reg    = '0;
        rate_reg    = '0;
        align_reg   = '0;
        width_reg   = '0;
        frames_left = '0;
        byte_idx    = '0;
    endtask

    task automatic push_error(input wsp_pkg::t_err code);
        wsp_pkg::t_result r;
        r            = '0;
        r.kind       = wsp_pkg::KIND_ERROR;
        r.error_code = code;
        phase_q      = PP_IDLE;
        decoded_due.push_back(r);
    endtask

    // work out what one accepted byte produces
    task automatic decode_byte(input logic [7:0] b, input logic st, input logic fin);
        logic [5:0]         pos;
        logic [31:0]        quot;
        int                 nbytes;
        logic signed [31:0] value;
        logic               last;
        wsp_pkg::t_result   r;
        if (st) begin
            phase_q = PP_HEAD;
            clear_parse();
        end
        case (phase_q)
            PP_HEAD: begin
                pos     = hdr_pos;
                tag_win = {tag_win[23:0], b};
                if (pos == wsp_pkg::HP_RIFF_END && tag_win != wsp_pkg::TAG_RIFF) begin
                    push_error(wsp_pkg::ERR_NOT_RIFF);
                    return;
                end
                if (pos == wsp_pkg::HP_WAVE_END)
                    field_acc = (tag_win != wsp_pkg::TAG_WAVE) ? 32'd1 : 32'd0;
                if (pos == wsp_pkg::HP_FMT_END
                    && (field_acc != 0 || tag_win != wsp_pkg::TAG_FMT)) begin
                    push_error(wsp_pkg::ERR_NOT_WAVE);
                    return;
                end
                // format word, low byte first
                if (pos == wsp_pkg::HP_FMT_LO)
                    field_acc = {24'd0, b};
                if (pos == wsp_pkg::HP_FMT_HI) begin
                    field_acc[15:8] = b;
                    if (field_acc != {16'd0, wsp_pkg::FMT_PCM}) begin
                        push_error(wsp_pkg::ERR_NOT_PCM);
                        return;
                    end
                end
                if (pos == wsp_pkg::HP_CH_LO)    chan_reg[7:0]   = b;
                if (pos == wsp_pkg::HP_CH_HI)    chan_reg[15:8]  = b;
                if (pos >= wsp_pkg::HP_RATE_0 && pos <= wsp_pkg::HP_RATE_3)
                    rate_reg[8*(pos - wsp_pkg::HP_RATE_0) +: 8] = b;
                if (pos == wsp_pkg::HP_ALIGN_LO) align_reg[7:0]  = b;
                if (pos == wsp_pkg::HP_ALIGN_HI) align_reg[15:8] = b;
                if (pos == wsp_pkg::HP_WIDTH_LO) width_reg[7:0]  = b;
                if (pos == wsp_pkg::HP_WIDTH_HI) width_reg[15:8] = b;
                if (pos >= wsp_pkg::HP_WIDTH_HI) begin
                    phase_q = PP_SCAN;
                    tag_win = '0;
                    hdr_pos = '0;
                end else begin
                    hdr_pos = pos + 6'd1;
                end
                if (fin)
                    push_error(wsp_pkg::ERR_TRUNCATED);
            end
            // sliding window looking for the data tag
            PP_SCAN: begin
                tag_win = {tag_win[23:0], b};
                if (tag_win == wsp_pkg::TAG_DATA) begin
                    phase_q   = PP_LEN;
                    hdr_pos   = '0;
                    field_acc = '0;
                end
                if (fin)
                    push_error(wsp_pkg::ERR_TRUNCATED);
            end
            PP_LEN: begin
                field_acc[8*hdr_pos[1:0] +: 8] = b;
                if (hdr_pos >= wsp_pkg::HP_LEN_END) begin
                    if (align_reg == 0) begin
                        push_error(wsp_pkg::ERR_ZERO_ALGN);
                        return;
                    end
                    quot        = field_acc / {16'd0, align_reg};
                    frames_left = quot;
                    field_acc   = '0;
                    byte_idx    = '0;
                    hdr_pos     = '0;
                    phase_q     = (fin || quot == 0) ? PP_IDLE : PP_DATA;
                    r                 = '0;
                    r.kind            = wsp_pkg::KIND_HEADER;
                    r.channels        = chan_reg;
                    r.sample_rate     = rate_reg;
                    r.block_align     = align_reg;
                    r.bits_per_sample = width_reg;
                    r.frame_count     = quot;
                    decoded_due.push_back(r);
                    return;
                end
                hdr_pos = hdr_pos + 6'd1;
                if (fin)
                    push_error(wsp_pkg::ERR_TRUNCATED);
            end
            // sample assembly, little-endian
            PP_DATA: begin
                if (frames_left == 0) begin
                    phase_q = PP_IDLE;
                    return;
                end
                case (width_reg)
                    wsp_pkg::WIDTH_8:  nbytes = 1;
                    wsp_pkg::WIDTH_16: nbytes = 2;
                    wsp_pkg::WIDTH_32: nbytes = 4;
                    default:           nbytes = 0;
                endcase
                if (nbytes == 0) begin
                    push_error(wsp_pkg::ERR_BAD_WIDTH);
                    return;
                end
                field_acc[8*byte_idx +: 8] = b;
                if (int'(byte_idx) + 1 >= nbytes) begin
                    if (nbytes == 1)
                        value = $signed({24'd0, field_acc[7:0]}) - 32'sd128;
                    else if (nbytes == 2)
                        value = {{16{field_acc[15]}}, field_acc[15:0]};
                    else
                        value = field_acc;
                    frames_left = frames_left - 32'd1;
                    last        = (frames_left == 0);
                    field_acc   = '0;
                    byte_idx    = '0;
                    if (last || fin)
                        phase_q = PP_IDLE;
                    r             = '0;
                    r.kind        = wsp_pkg::KIND_SAMPLE;
                    r.sample      = value;
                    r.last_sample = last;
                    decoded_due.push_back(r);
                    return;
                end
                byte_idx = byte_idx + 2'd1;
                if (fin)
                    phase_q = PP_IDLE;
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic compare_result();
        wsp_pkg::t_result want;
        results_seen++;
        if (decoded_due.size() == 0) begin
            report_mismatch("item arrived with nothing expected");
            return;
        end
        want = decoded_due.pop_front();
        check_field("kind", 32'(i_out_tuser), 32'(want.kind));
        check_field("sample", i_out_tdata[31:0], want.sample);
        check_field("last_sample", 32'(i_out_tlast), 32'(want.last_sample));
        check_field("channels", 32'(i_out_tdata[47:32]), 32'(want.channels));
        check_field("sample_rate", i_out_tdata[79:48], want.sample_rate);
        check_field("block_align", 32'(i_out_tdata[95:80]), 32'(want.block_align));
        check_field("bits_per_sample", 32'(i_out_tdata[111:96]),
                    32'(want.bits_per_sample));
        check_field("frame_count", i_out_tdata[143:112], want.frame_count);
        check_field("error_code", 32'(i_out_tdata[146:144]), 32'(want.error_code));
    endtask

    // result side first: a result never leaves on the edge its byte enters
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase_q = PP_IDLE;
            clear_parse();
            decoded_due.delete();
        end else begin
            if (i_out_tvalid && i_out_tready)
                compare_result();
            if (i_in_tvalid && i_in_tready)
                decode_byte(i_in_tdata, i_in_tuser, i_in_tlast);
            if (i_drain_done && !drain_checked) begin
                drain_checked = 1'b1;
                if (decoded_due.size() != 0)
                    report_mismatch($sformatf("%0d expected items never arrived",
                                              decoded_due.size()));
            end
        end
        o_fail_count   <= fail_count;
        o_pending      <= decoded_due.size();
        o_results_seen <= results_seen;
    end

endmodule

`default_nettype wire

@@ sim/wav_stream_parser_top_tb.sv @@
`default_nettype none

module wav_stream_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 800;
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int BODY_AT      = 44;   // first data byte with no extra chunk bytes

    typedef struct {
        logic [31:0] riff;
        logic [31:0] wave;
        logic [31:0] fmt_tag;
        logic [15:0] fmt_code;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] align;
        logic [15:0] bits;
        logic [31:0] data_len;
        int          junk_len;
        int          body_len;
    } t_wav_spec;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = '0;  // byte_value
    logic                   s_axis_tuser  = 1'b0; // file_start
    logic                   s_axis_tlast  = 1'b0; // file_end
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // sample, channels, sample_rate, block_align, bits_per_sample,
    // frame_count, error_code, zero fill
    logic [wsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;          // kind
    logic                   m_axis_tlast;          // last_sample

    logic       drain_done   = 1'b0;
    int         fail_count;
    int         pending;
    int         results_seen;
    int         src_idle_pct  = 12;
    int         sink_idle_pct = 82;
    int         bytes_sent    = 0;
    int         files_sent    = 0;
    int         cycle_count   = 0;
    logic [7:0] wav_bytes[$];
    logic [7:0] body_fill[$];

    always #5ns i_clk = ~i_clk;

    wav_stream_parser_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    wav_stream_parser_checker result_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_tvalid    (s_axis_tvalid),
        .i_in_tready    (s_axis_tready),
        .i_in_tdata     (s_axis_tdata),
        .i_in_tuser     (s_axis_tuser),
        .i_in_tlast     (s_axis_tlast),
        .i_out_tvalid   (m_axis_tvalid),
        .i_out_tready   (m_axis_tready),
        .i_out_tdata    (m_axis_tdata),
        .i_out_tuser    (m_axis_tuser),
        .i_out_tlast    (m_axis_tlast),
        .i_drain_done   (drain_done),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    // receiver stalls at random
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[wav_stream_parser_top] ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic st, input logic fin);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= st;
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    function automatic t_wav_spec pcm_spec(input int bits, input int chans, input int frames);
        t_wav_spec sp;
        int        nbytes;
        nbytes      = (bits == 8 || bits == 16 || bits == 32) ? bits / 8 : 1;
        sp.riff     = wsp_pkg::TAG_RIFF;
        sp.wave     = wsp_pkg::TAG_WAVE;
        sp.fmt_tag  = wsp_pkg::TAG_FMT;
        sp.fmt_code = wsp_pkg::FMT_PCM;
        sp.channels = 16'(chans);
        sp.rate     = 32'd44100;
        sp.bits     = 16'(bits);
        sp.align    = 16'(chans * bits / 8);
        sp.data_len = 32'(frames) * 32'(sp.align);
        sp.junk_len = 0;
        sp.body_len = frames * nbytes;
        return sp;
    endfunction

    // lay out one file; body bytes come from body_fill first, then random
    task automatic build_wav(input t_wav_spec sp);
        logic [7:0] b;
        wav_bytes.delete();
        for (int k = 3; k >= 0; k--) wav_bytes.push_back(sp.riff[8*k +: 8]);
        for (int k = 0; k < 4; k++) wav_bytes.push_back(8'($urandom));
        for (int k = 3; k >= 0; k--) wav_bytes.push_back(sp.wave[8*k +: 8]);
        for (int k = 3; k >= 0; k--) wav_bytes.push_back(sp.fmt_tag[8*k +: 8]);
        wav_bytes.push_back(8'd16);
        repeat (3) wav_bytes.push_back(8'd0);
        for (int k = 0; k < 2; k++) wav_bytes.push_back(sp.fmt_code[8*k +: 8]);
        for (int k = 0; k < 2; k++) wav_bytes.push_back(sp.channels[8*k +: 8]);
        for (int k = 0; k < 4; k++) wav_bytes.push_back(sp.rate[8*k +: 8]);
        for (int k = 0; k < 4; k++) wav_bytes.push_back(8'($urandom));
        for (int k = 0; k < 2; k++) wav_bytes.push_back(sp.align[8*k +: 8]);
        for (int k = 0; k < 2; k++) wav_bytes.push_back(sp.bits[8*k +: 8]);
        // extra chunk bytes, a partial data tag first when there is room
        for (int k = 0; k < sp.junk_len; k++) begin
            if (k < 3 && sp.junk_len > 3) begin
                b = wsp_pkg::TAG_DATA[31-8*k -: 8];
            end else begin
                b = 8'($urandom);
                if (k == 3 && b == wsp_pkg::TAG_DATA[7:0])
                    b = ~b;
            end
            wav_bytes.push_back(b);
        end
        for (int k = 3; k >= 0; k--) wav_bytes.push_back(wsp_pkg::TAG_DATA[8*k +: 8]);
        for (int k = 0; k < 4; k++) wav_bytes.push_back(sp.data_len[8*k +: 8]);
        for (int k = 0; k < sp.body_len; k++)
            wav_bytes.push_back(body_fill.size() != 0 ? body_fill.pop_front()
                                                      : 8'($urandom));
        body_fill.delete();
    endtask

    // end_at marks the byte carrying file_end, the file stops there
    task automatic send_file(input int end_at);
        foreach (wav_bytes[k]) begin
            send_byte(wav_bytes[k], k == 0, k == end_at);
            if (k == end_at)
                break;
        end
        files_sent++;
    endtask

    task automatic run_directed();
        t_wav_spec sp;
        // bytes before any start are ignored
        send_byte(8'hA5, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b0);
        // 8-bit extremes, trailing bytes after the last sample, zero channels and rate
        sp          = pcm_spec(8, 1, 4);
        sp.channels = 16'd0;
        sp.rate     = 32'd0;
        sp.body_len = 6;
        body_fill   = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        build_wav(sp);
        send_file(-1);
        // 16-bit extremes, file end on the last sample byte
        sp        = pcm_spec(16, 1, 4);
        body_fill = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF};
        build_wav(sp);
        send_file(wav_bytes.size() - 1);
        // 32-bit extremes behind an extra chunk with a partial data tag
        sp          = pcm_spec(32, 1, 3);
        sp.junk_len = 5;
        body_fill   = '{8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                        8'hFF, 8'hFF, 8'hFF, 8'hFF};
        build_wav(sp);
        send_file(-1);
        // bad riff tag, then with file end on the same byte
        sp      = pcm_spec(16, 2, 2);
        sp.riff = wsp_pkg::TAG_RIFF ^ 32'h1;
        build_wav(sp);
        send_file(-1);
        send_file(3);
        // bad wave and fmt tags
        sp      = pcm_spec(16, 2, 2);
        sp.wave = wsp_pkg::TAG_WAVE ^ 32'h0100_0000;
        build_wav(sp);
        send_file(-1);
        sp         = pcm_spec(16, 2, 2);
        sp.fmt_tag = wsp_pkg::TAG_FMT ^ 32'h20;
        build_wav(sp);
        send_file(-1);
        // not pcm, low byte then high byte
        sp          = pcm_spec(8, 1, 2);
        sp.fmt_code = 16'd3;
        build_wav(sp);
        send_file(-1);
        sp.fmt_code = 16'h0101;
        build_wav(sp);
        send_file(-1);
        // end inside the fixed header, on the data tag, inside the length
        sp = pcm_spec(8, 1, 2);
        build_wav(sp);
        send_file(10);
        send_file(BODY_AT - 5);
        send_file(BODY_AT - 3);
        // end on the last length byte: header still comes out
        send_file(BODY_AT - 1);
        // zero block align, plain and with end on the last length byte
        sp       = pcm_spec(16, 1, 2);
        sp.align = 16'd0;
        build_wav(sp);
        send_file(-1);
        send_file(BODY_AT - 1);
        // zero frame count: data bytes are ignored
        sp          = pcm_spec(16, 2, 0);
        sp.data_len = 32'd3;
        sp.body_len = 3;
        build_wav(sp);
        send_file(-1);
        // unsupported width with frames, then without
        sp = pcm_spec(12, 1, 2);
        build_wav(sp);
        send_file(-1);
        sp          = pcm_spec(24, 1, 0);
        sp.body_len = 4;
        build_wav(sp);
        send_file(-1);
        // end in the middle of the second sample
        sp = pcm_spec(16, 1, 3);
        build_wav(sp);
        send_file(BODY_AT + 2);
        // all header fields at their maximum
        sp          = pcm_spec(16, 1, 1);
        sp.channels = 16'hFFFF;
        sp.rate     = 32'hFFFF_FFFF;
        sp.align    = 16'hFFFF;
        sp.bits     = 16'hFFFF;
        sp.data_len = 32'hFFFF_FFFF;
        sp.body_len = 2;
        build_wav(sp);
        send_file(-1);
        // largest frame count, cut after three samples
        sp          = pcm_spec(8, 1, 1);
        sp.data_len = 32'hFFFF_FFFF;
        sp.body_len = 3;
        build_wav(sp);
        send_file(wav_bytes.size() - 1);
        // restart in the middle of a sample
        sp          = pcm_spec(16, 1, 4);
        sp.body_len = 3;
        build_wav(sp);
        send_file(-1);
    endtask

    task automatic send_random_file();
        t_wav_spec sp;
        int        bits;
        int        chans;
        int        frames;
        int        pick;
        int        end_at;
        bits   = ($urandom_range(99) < 75) ? (8 << $urandom_range(2))
               : (($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(1, 40));
        chans  = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(1, 8);
        frames = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(12);
        sp      = pcm_spec(bits, chans, frames);
        sp.rate = $urandom;
        // odd block aligns, sometimes zero
        pick = $urandom_range(19);
        if (pick == 0) begin
            sp.align    = 16'd0;
            sp.data_len = $urandom;
        end else if (pick == 1) begin
            sp.align    = 16'($urandom);
            sp.data_len = 32'(frames) * 32'(sp.align);
        end
        if (sp.align > 1 && $urandom_range(1) == 1)
            sp.data_len += $urandom_range(sp.align - 1);
        // broken headers and cut bodies
        pick = $urandom_range(99);
        if (pick < 4)
            sp.riff ^= 32'($urandom_range(1, 255)) << (8 * $urandom_range(3));
        else if (pick < 8)
            sp.wave ^= 32'($urandom_range(1, 255)) << (8 * $urandom_range(3));
        else if (pick < 12)
            sp.fmt_tag ^= 32'($urandom_range(1, 255)) << (8 * $urandom_range(3));
        else if (pick < 16)
            sp.fmt_code = 16'($urandom);
        if (pick >= 16 && pick < 24)
            sp.body_len = $urandom_range(sp.body_len);
        else
            sp.body_len += $urandom_range(3);
        sp.junk_len = $urandom_range(6);
        build_wav(sp);
        pick = $urandom_range(99);
        if (pick < 15)
            end_at = wav_bytes.size() - 1;
        else if (pick < 27)
            end_at = $urandom_range(wav_bytes.size() - 1);
        else
            end_at = -1;
        send_file(end_at);
        // stray bytes between files
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom), $urandom_range(7) == 0, $urandom_range(3) == 0);
    endtask

    initial begin
        int random_base;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        // random files under three idle mixes
        random_base = bytes_sent;
        while (bytes_sent - random_base < RANDOM_BYTES) begin
            if (bytes_sent - random_base < RANDOM_BYTES / 3) begin
                src_idle_pct  = 12;
                sink_idle_pct = 82;
            end else if (bytes_sent - random_base < 2 * RANDOM_BYTES / 3) begin
                src_idle_pct  = 82;
                sink_idle_pct = 12;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            send_random_file();
        end
        s_axis_tvalid <= 1'b0;

        // drain, then allow for the header divide
        for (int w = 0; w < 5000 && pending != 0; w++)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        drain_done <= 1'b1;
        repeat (3) @(posedge i_clk);

        $display("covered %0d bytes in %0d files, %0d result items compared",
                 bytes_sent, files_sent, results_seen);
        $display("including bad tags, non-pcm, truncation, zero align and bad widths");
        if (fail_count == 0)
            $display("[wav_stream_parser_top] OK");
        else
            $display("[wav_stream_parser_top] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
